### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the queue RTL; all are clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every edge out of reset.
`define DEQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// A condition that must be followed by a property in the next cycle.
`define DEQ_ASSERT_NEXT(name, trig, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error(msg);

`endif

### src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Types, operation codes and status codes of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DATA_W        = 32;
  localparam int COUNT_W       = 5;
  localparam int DEPTH_DEFAULT = 16;

  typedef logic [1:0]               mode_t;
  typedef logic [1:0]               status_t;
  typedef logic [COUNT_W-1:0]       count_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam mode_t MODE_PUSH_FRONT = 2'd0;
  localparam mode_t MODE_PUSH_BACK  = 2'd1;
  localparam mode_t MODE_POP_FRONT  = 2'd2;
  localparam mode_t MODE_POP_BACK   = 2'd3;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

### src/deq_req_if.sv
// ----------------------------------------------------------------------------
// deq_req_if
// Request channel: one operation word with its push value.
// ----------------------------------------------------------------------------
interface deq_req_if import deq_pkg::*; ();

  logic  valid;
  logic  ready;
  mode_t mode;
  data_t value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);

endinterface

### src/deq_rsp_if.sv
// ----------------------------------------------------------------------------
// deq_rsp_if
// Response channel: status, count and the front and back values.
// ----------------------------------------------------------------------------
interface deq_rsp_if import deq_pkg::*; ();

  logic    valid;
  logic    ready;
  status_t status;
  count_t  entry_count;
  data_t   front_value;
  data_t   back_value;

  modport source (output valid, output status, output entry_count,
                  output front_value, output back_value, input ready);
  modport sink   (input valid, input status, input entry_count,
                  input front_value, input back_value, output ready);

endinterface

### src/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Slot store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_ram import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  data_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output data_t         rdata
);

  data_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/double_ended_queue_unit.sv
// Each request word passes the busy stage, where the slot read is awaited, and
// then the output register. No new request is taken while busy; a pop must wait
// for the slot memory's one-cycle read to learn the new front or back value.
// A request is taken while an earlier result still waits in the output register.
// Reset sets the empty-queue indices and clears the count and held front/back
// values; the memory is not cleared, and no slot is read before a push writes it.
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit values in a circular slot memory.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module double_ended_queue_unit import deq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_COUNT  = CW'(1);

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    idx_inc = (i == LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    idx_dec = (i == '0) ? LAST : i - 1'b1;
  endfunction

  // Queue state. When empty, back_index sits one slot behind front_index.
  logic [AW-1:0] front_index;
  logic [AW-1:0] back_index;
  logic [CW-1:0] held_count;
  data_t         front_val;
  data_t         back_val;

  // Second stage: waiting for read data and a free output register.
  logic    busy;
  status_t pend_status;
  logic    pend_front;
  logic    pend_back;

  logic    out_valid;
  status_t out_status;
  count_t  out_count;
  data_t   out_front;
  data_t   out_back;

  logic          in_fire;
  logic          done_fire;
  logic          full;
  logic          empty;
  logic          last_one;
  status_t       status_acc;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_front;
  logic          rd_back;
  logic [AW-1:0] rd_addr;
  data_t         rd_data;

  assign req.ready = !busy;
  assign in_fire   = req.valid && !busy;
  assign done_fire = busy && (!out_valid || rsp.ready);

  assign full     = (held_count == FULL_COUNT);
  assign empty    = (held_count == '0);
  assign last_one = (held_count == ONE_COUNT);

  always_comb begin
    status_acc = ST_DONE;
    wr_en      = 1'b0;
    wr_addr    = idx_inc(back_index);
    rd_front   = 1'b0;
    rd_back    = 1'b0;
    rd_addr    = idx_inc(front_index);
    case (req.mode)
      MODE_PUSH_FRONT: begin
        if (full) begin
          status_acc = ST_FULL;
        end else begin
          wr_en   = in_fire;
          wr_addr = idx_dec(front_index);
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          status_acc = ST_FULL;
        end else begin
          wr_en = in_fire;
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status_acc = ST_EMPTY;
        end else begin
          rd_front = !last_one;
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          status_acc = ST_EMPTY;
        end else begin
          rd_back = !last_one;
          rd_addr = idx_dec(back_index);
        end
      end
      default: begin
        status_acc = ST_DONE;
      end
    endcase
  end

  deq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (req.value),
    .re    (in_fire && (rd_front || rd_back)),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      back_index  <= LAST;
      held_count  <= '0;
      front_val   <= '0;
      back_val    <= '0;
      busy        <= 1'b0;
      pend_front  <= 1'b0;
      pend_back   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_fire) begin
        busy       <= 1'b1;
        pend_front <= rd_front;
        pend_back  <= rd_back;
        if (status_acc == ST_DONE) begin
          case (req.mode)
            MODE_PUSH_FRONT: begin
              front_index <= idx_dec(front_index);
              held_count  <= held_count + 1'b1;
              front_val   <= req.value;
              if (empty) begin
                back_val <= req.value;
              end
            end
            MODE_PUSH_BACK: begin
              back_index <= idx_inc(back_index);
              held_count <= held_count + 1'b1;
              back_val   <= req.value;
              if (empty) begin
                front_val <= req.value;
              end
            end
            MODE_POP_FRONT: begin
              front_index <= idx_inc(front_index);
              held_count  <= held_count - 1'b1;
              if (last_one) begin
                front_val <= '0;
                back_val  <= '0;
              end
            end
            MODE_POP_BACK: begin
              back_index <= idx_dec(back_index);
              held_count <= held_count - 1'b1;
              if (last_one) begin
                front_val <= '0;
                back_val  <= '0;
              end
            end
            default: begin
              held_count <= held_count;
            end
          endcase
        end
      end
      if (done_fire) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
        if (pend_front) begin
          front_val <= rd_data;
        end
        if (pend_back) begin
          back_val <= rd_data;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_status <= status_acc;
    end
    if (done_fire) begin
      out_status <= pend_status;
      out_count  <= COUNT_W'(held_count);
      out_front  <= pend_front ? rd_data : front_val;
      out_back   <= pend_back ? rd_data : back_val;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.entry_count = out_count;
  assign rsp.front_value = out_front;
  assign rsp.back_value  = out_back;

  `DEQ_ASSERT(a_count_bound, held_count <= FULL_COUNT, "entry count exceeds depth")
  `DEQ_ASSERT(a_empty_values, (!busy && empty) |-> (front_val == '0 && back_val == '0),
    "empty queue holds nonzero front or back value")
  `DEQ_ASSERT(a_one_read, !(pend_front && pend_back), "two slot reads pending at once")
  `DEQ_ASSERT_NEXT(a_empty_wrap, in_fire, !empty || (back_index == idx_dec(front_index)),
    "back index not behind front index when empty")

endmodule

### dv/double_ended_queue_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit_tb
// Drives push and pop words into the double-ended queue and checks every
// response word against a cycle-free software copy of the queue. Directed
// words cover the empty, single-entry, full and wrap cases, then random
// words run under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;
  import deq_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 120;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    status_t status;
    count_t  entry_count;
    data_t   front_value;
    data_t   back_value;
  } deq_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  deq_req_if req_ch ();
  deq_rsp_if rsp_ch ();

  double_ended_queue_unit #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // Software copy of the queue.
  data_t            shadow_slots [DEPTH];
  logic [IDX_W-1:0] shadow_head = '0;
  count_t           shadow_fill = '0;

  deq_result_t pending_results [$];
  int          mismatches  = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_start = 1'b0;
  int          hold_left  = 0;

  function automatic deq_result_t apply_operation(mode_t mode, data_t value);
    deq_result_t      res;
    logic [IDX_W-1:0] tail;
    res.status = ST_DONE;
    if (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_BACK) begin
      if (shadow_fill == DEPTH) begin
        res.status = ST_FULL;
      end else if (mode == MODE_PUSH_FRONT) begin
        shadow_head = shadow_head - 1'b1;
        shadow_slots[shadow_head] = value;
        shadow_fill = shadow_fill + 1'b1;
      end else begin
        tail = IDX_W'(shadow_head + shadow_fill);
        shadow_slots[tail] = value;
        shadow_fill = shadow_fill + 1'b1;
      end
    end else begin
      if (shadow_fill == 0) begin
        res.status = ST_EMPTY;
      end else if (mode == MODE_POP_FRONT) begin
        shadow_head = shadow_head + 1'b1;
        shadow_fill = shadow_fill - 1'b1;
      end else begin
        shadow_fill = shadow_fill - 1'b1;
      end
    end
    res.entry_count = shadow_fill;
    if (shadow_fill == 0) begin
      res.front_value = '0;
      res.back_value  = '0;
    end else begin
      tail = IDX_W'(shadow_head + shadow_fill - 1'b1);
      res.front_value = shadow_slots[shadow_head];
      res.back_value  = shadow_slots[tail];
    end
    return res;
  endfunction

  // Sends one request word; valid stays high so the next word can follow
  // back to back.
  task automatic send_word(mode_t mode, data_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
    end
    @(negedge clk);
    req_ch.valid = 1'b1;
    req_ch.mode  = mode;
    req_ch.value = value;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(apply_operation(mode, value));
  endtask

  function automatic data_t pick_value();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic mode_t pick_mode(int push_pct);
    if ($urandom_range(99) < push_pct) begin
      return $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
    end
    return $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
  endfunction

  task automatic test_empty_pops();
    send_word(MODE_POP_FRONT, 32'sh7fff_ffff);
    send_word(MODE_POP_BACK, 32'sh8000_0000);
  endtask

  task automatic test_single_entry();
    send_word(MODE_PUSH_FRONT, 32'sh7fff_ffff);
    send_word(MODE_POP_BACK, '0);
    send_word(MODE_PUSH_BACK, 32'sh8000_0000);
    send_word(MODE_POP_FRONT, -1);
  endtask

  // Pushing at the front from an empty queue wraps the head below slot zero.
  task automatic test_fill_and_wrap();
    for (int i = 0; i < DEPTH; i++) begin
      send_word((i % 2) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
                (i % 3 == 0) ? -data_t'(i + 1) : data_t'(32'h5a5a_0000 | i));
    end
    send_word(MODE_PUSH_FRONT, -1);
    send_word(MODE_PUSH_BACK, 32'sh7fff_ffff);
  endtask

  // Runs of fill-biased and drain-biased words push the queue between
  // empty and full over and over.
  task automatic test_random(int words, int idle_pct, int stall_pct);
    int push_pct;
    int run_left;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    run_left = 0;
    push_pct = 50;
    for (int i = 0; i < words; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(60, 15);
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      run_left--;
      send_word(pick_mode(push_pct), pick_value());
    end
  endtask

  // The receiver holds off while words keep coming, so the block must stall
  // its request side.
  task automatic test_backpressure(int words);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_start = 1'b1;
    for (int i = 0; i < words; i++) begin
      send_word(pick_mode(60), pick_value());
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode  = MODE_PUSH_FRONT;
    req_ch.value = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_pops();
    test_single_entry();
    test_fill_and_wrap();
    test_random(400, 0, 0);
    test_random(400, 63, 0);
    test_random(400, 0, 63);
    test_random(400, 10, 10);
    test_backpressure(50);

    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready = 1'b0;
      end else begin
        rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic check_field(string field, longint expected, longint actual);
    if (expected != actual) begin
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, field, expected, actual);
      end
    end
  endtask

  always @(posedge clk) begin
    deq_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
          $display("%0t: response word with nothing expected, expected none, actual %0d %0d %0d %0d",
                   $time, rsp_ch.status, rsp_ch.entry_count,
                   rsp_ch.front_value, rsp_ch.back_value);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, rsp_ch.status);
        check_field("entry_count", want.entry_count, rsp_ch.entry_count);
        check_field("front_value", want.front_value, rsp_ch.front_value);
        check_field("back_value", want.back_value, rsp_ch.back_value);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

endmodule
